// File: src/alpha_box_blur_region_assert.svh
// ----------------------------------------------------------------------------
// alpha box blur region assertion macros
// clocked assertion helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ALPHA_BOX_BLUR_REGION_ASSERT_SVH
`define ALPHA_BOX_BLUR_REGION_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ABB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ABB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ABB_ASSERT(lbl, prop, msg)
`define ABB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: src/abb_pkg.sv
// ----------------------------------------------------------------------------
// abb_pkg
// shared constants, types and the reciprocal table of the region alpha blur
// ----------------------------------------------------------------------------
package abb_pkg;

  localparam int MaxWidth    = 1024;
  localparam int MaxRadius   = 3;
  localparam int RingRows    = 2 * MaxRadius + 2;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int RowW        = 10;
  localparam int SlotW       = $clog2(RingRows);
  localparam int AddrW       = SlotW + ColW;
  localparam int AlphaShift  = 24;
  localparam int RecipShift  = 20;
  localparam int SumW        = 14;
  localparam int CountW      = 6;
  localparam int RecipW      = RecipShift + 1;
  localparam int NumRegs     = 7;

  localparam logic [2:0] RegFrameWidth  = 3'd0;
  localparam logic [2:0] RegFrameHeight = 3'd1;
  localparam logic [2:0] RegRegionLeft  = 3'd2;
  localparam logic [2:0] RegRegionTop   = 3'd3;
  localparam logic [2:0] RegRegionW     = 3'd4;
  localparam logic [2:0] RegRegionH     = 3'd5;
  localparam logic [2:0] RegBlurRadius  = 3'd6;

  // effective configuration; frame sizes and radius already clamped
  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [9:0]  left;
    logic [9:0]  top;
    logic [10:0] reg_w;
    logic [10:0] reg_h;
    logic [1:0]  radius;
  } cfg_t;

  typedef struct packed {
    logic             wr;
    logic [AddrW-1:0] waddr;
    logic [31:0]      wdata;
    logic             emit;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [SlotW-1:0] slot;
    logic             blur;
    logic             last;
  } job_t;

  // ceil(2^20 / c), exact floor division for sums below 2^14 and c up to 49
  function automatic logic [RecipW-1:0] recip(input logic [CountW-1:0] c);
    logic [RecipW-1:0] m;
    case (c)
      6'd1:  m = 21'd1048576;
      6'd2:  m = 21'd524288;
      6'd3:  m = 21'd349526;
      6'd4:  m = 21'd262144;
      6'd5:  m = 21'd209716;
      6'd6:  m = 21'd174763;
      6'd7:  m = 21'd149797;
      6'd8:  m = 21'd131072;
      6'd9:  m = 21'd116509;
      6'd10: m = 21'd104858;
      6'd11: m = 21'd95326;
      6'd12: m = 21'd87382;
      6'd13: m = 21'd80660;
      6'd14: m = 21'd74899;
      6'd15: m = 21'd69906;
      6'd16: m = 21'd65536;
      6'd17: m = 21'd61681;
      6'd18: m = 21'd58255;
      6'd19: m = 21'd55189;
      6'd20: m = 21'd52429;
      6'd21: m = 21'd49933;
      6'd22: m = 21'd47663;
      6'd23: m = 21'd45591;
      6'd24: m = 21'd43691;
      6'd25: m = 21'd41944;
      6'd26: m = 21'd40330;
      6'd27: m = 21'd38837;
      6'd28: m = 21'd37450;
      6'd29: m = 21'd36158;
      6'd30: m = 21'd34953;
      6'd31: m = 21'd33826;
      6'd32: m = 21'd32768;
      6'd33: m = 21'd31776;
      6'd34: m = 21'd30841;
      6'd35: m = 21'd29960;
      6'd36: m = 21'd29128;
      6'd37: m = 21'd28340;
      6'd38: m = 21'd27595;
      6'd39: m = 21'd26887;
      6'd40: m = 21'd26215;
      6'd41: m = 21'd25576;
      6'd42: m = 21'd24967;
      6'd43: m = 21'd24386;
      6'd44: m = 21'd23832;
      6'd45: m = 21'd23302;
      6'd46: m = 21'd22796;
      6'd47: m = 21'd22311;
      6'd48: m = 21'd21846;
      6'd49: m = 21'd21400;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: src/abb_front.sv
// ----------------------------------------------------------------------------
// abb_front
// tracks input and output positions, decides which pixel is due, issues jobs
// ----------------------------------------------------------------------------
module abb_front import abb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        restart_i,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] pixel_in_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output job_t        q_job_o
);

  logic [ColW-1:0]  in_col_q, in_col_d, em_col_q, em_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, em_row_q, em_row_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d, em_slot_q, em_slot_d;
  logic             ahead_q, ahead_d;

  logic        accept, wr, ready, in_wrap, blur, last;
  logic [10:0] col_inc, row_inc, ecol_inc, erow_inc, ry, rx;
  logic [11:0] reg_right, reg_bottom;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign wr         = ~action_i;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_slot_d = in_slot_q;
    in_wrap   = 1'b0;
    col_inc   = {1'b0, in_col_q} + 11'd1;
    row_inc   = {1'b0, in_row_q} + 11'd1;
    if (wr) begin
      if (col_inc >= cfg_i.width) begin
        in_col_d  = '0;
        in_slot_d = in_slot_q + SlotW'(1);
        if (row_inc >= cfg_i.height) begin
          in_row_d = '0;
          in_wrap  = 1'b1;
        end else begin
          in_row_d = row_inc[RowW-1:0];
        end
      end else begin
        in_col_d = col_inc[ColW-1:0];
      end
    end

    // last tap this pixel needs, clipped to the frame
    ry = {1'b0, em_row_q} + {9'd0, cfg_i.radius};
    if (ry > cfg_i.height - 11'd1) ry = cfg_i.height - 11'd1;
    rx = {1'b0, em_col_q} + {9'd0, cfg_i.radius};
    if (rx > cfg_i.width - 11'd1) rx = cfg_i.width - 11'd1;

    ready = (ahead_q | in_wrap) || ({1'b0, in_row_d} > ry) ||
            (({1'b0, in_row_d} == ry) && ({1'b0, in_col_d} > rx));

    reg_right  = {2'b0, cfg_i.left} + {1'b0, cfg_i.reg_w};
    reg_bottom = {2'b0, cfg_i.top} + {1'b0, cfg_i.reg_h};
    blur = (em_col_q >= cfg_i.left) && ({2'b0, em_col_q} < reg_right) &&
           (em_row_q >= cfg_i.top) && ({2'b0, em_row_q} < reg_bottom);
    last = ({1'b0, em_row_q} == cfg_i.height - 11'd1) &&
           ({1'b0, em_col_q} == cfg_i.width - 11'd1);

    em_col_d  = em_col_q;
    em_row_d  = em_row_q;
    em_slot_d = em_slot_q;
    ahead_d   = ahead_q | in_wrap;
    ecol_inc  = {1'b0, em_col_q} + 11'd1;
    erow_inc  = {1'b0, em_row_q} + 11'd1;
    if (ready) begin
      if (ecol_inc >= cfg_i.width) begin
        em_col_d  = '0;
        em_slot_d = em_slot_q + SlotW'(1);
        if (erow_inc >= cfg_i.height) begin
          em_row_d = '0;
          ahead_d  = 1'b0;
        end else begin
          em_row_d = erow_inc[RowW-1:0];
        end
      end else begin
        em_col_d = ecol_inc[ColW-1:0];
      end
    end

    q_job_o.wr    = wr;
    q_job_o.waddr = {in_slot_q, in_col_q};
    q_job_o.wdata = pixel_in_i;
    q_job_o.emit  = ready;
    q_job_o.col   = em_col_q;
    q_job_o.row   = em_row_q;
    q_job_o.slot  = em_slot_q;
    q_job_o.blur  = blur;
    q_job_o.last  = last;
  end

  assign q_push_o = accept & (wr | ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_slot_q <= '0;
      em_col_q  <= '0;
      em_row_q  <= '0;
      em_slot_q <= '0;
      ahead_q   <= 1'b0;
    end else if (restart_i) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_slot_q <= '0;
      em_col_q  <= '0;
      em_row_q  <= '0;
      em_slot_q <= '0;
      ahead_q   <= 1'b0;
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_slot_q <= in_slot_d;
      em_col_q  <= em_col_d;
      em_row_q  <= em_row_d;
      em_slot_q <= em_slot_d;
      ahead_q   <= ahead_d;
    end
  end

endmodule

// File: src/abb_queue.sv
// ----------------------------------------------------------------------------
// abb_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module abb_queue import abb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic flush_i,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t       slots_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) slots_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else if (flush_i) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) wptr_q <= ~wptr_q;
      if (pop_i && !empty_o) rptr_q <= ~rptr_q;
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: src/abb_back.sv
// ----------------------------------------------------------------------------
// abb_back
// line store, window tap walk, mean by reciprocal and result register
// ----------------------------------------------------------------------------
module abb_back import abb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              flush_i,
  input  cfg_t              cfg_i,
  input  logic              q_empty_i,
  input  job_t              q_job_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       pixel_out_o,
  output logic [ColW-1:0]   out_col_o,
  output logic [RowW-1:0]   out_row_o,
  output logic              frame_end_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWrite = 3'd1;
  localparam logic [2:0] StTap   = 3'd2;
  localparam logic [2:0] StFlush = 3'd3;
  localparam logic [2:0] StMul   = 3'd4;
  localparam logic [2:0] StFin   = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;
  job_t       job_q;
  logic [2:0] ty_q, ty_d, tx_q, tx_d;

  logic [31:0] mem [RingRows*MaxWidth];
  logic [31:0] rdata_q;
  logic        tap_p1_q, ctr_p1_q;

  logic [SumW-1:0]        sum_q;
  logic [CountW-1:0]      cnt_q;
  logic [23:0]            rgb_q;
  logic [SumW+RecipW-1:0] prod_q;

  logic [1:0]        re;
  logic [2:0]        span;
  logic signed [3:0] dy, dx;
  logic signed [11:0] ny, nx;
  logic              tap_ok, is_ctr, mem_re;
  logic [AddrW-1:0]  raddr;

  assign re   = job_q.blur ? cfg_i.radius : 2'd0;
  assign span = {re, 1'b0};
  assign dy   = $signed({1'b0, ty_q}) - $signed({2'b0, re});
  assign dx   = $signed({1'b0, tx_q}) - $signed({2'b0, re});
  assign ny   = $signed({2'b0, job_q.row}) + 12'(dy);
  assign nx   = $signed({2'b0, job_q.col}) + 12'(dx);
  assign tap_ok = (ny >= 0) && (ny < $signed({1'b0, cfg_i.height})) &&
                  (nx >= 0) && (nx < $signed({1'b0, cfg_i.width}));
  assign is_ctr = (ty_q == {1'b0, re}) && (tx_q == {1'b0, re});
  // ring row wraps modulo the ring depth
  assign raddr  = {job_q.slot + dy[SlotW-1:0], nx[ColW-1:0]};
  assign mem_re = (state_q == StTap);

  assign q_pop_o     = (state_q == StIdle) && !q_empty_i;
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    ty_d    = ty_q;
    tx_d    = tx_q;
    case (state_q)
      StIdle: begin
        ty_d = '0;
        tx_d = '0;
        if (!q_empty_i) state_d = q_job_i.wr ? StWrite : StTap;
      end
      StWrite: state_d = job_q.emit ? StTap : StIdle;
      StTap: begin
        if (tx_q == span) begin
          tx_d = '0;
          if (ty_q == span) state_d = StFlush;
          else ty_d = ty_q + 3'd1;
        end else begin
          tx_d = tx_q + 3'd1;
        end
      end
      StFlush: state_d = StMul;
      StMul:   state_d = StFin;
      StFin:   state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StWrite) mem[job_q.waddr] <= job_q.wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ty_q     <= '0;
      tx_q     <= '0;
      tap_p1_q <= 1'b0;
      ctr_p1_q <= 1'b0;
    end else if (flush_i) begin
      state_q  <= StIdle;
      ty_q     <= '0;
      tx_q     <= '0;
      tap_p1_q <= 1'b0;
      ctr_p1_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ty_q     <= ty_d;
      tx_q     <= tx_d;
      tap_p1_q <= mem_re & tap_ok;
      ctr_p1_q <= mem_re & is_ctr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (tap_p1_q) begin
      sum_q <= sum_q + {6'd0, rdata_q[AlphaShift +: 8]};
      cnt_q <= cnt_q + 6'd1;
    end
    if (ctr_p1_q) rgb_q <= rdata_q[AlphaShift-1:0];
    if (state_q == StMul) prod_q <= sum_q * recip(cnt_q);
    if (state_q == StFin) begin
      pixel_out_o <= {prod_q[RecipShift +: 8], rgb_q};
      out_col_o   <= job_q.col;
      out_row_o   <= job_q.row;
      frame_end_o <= job_q.last;
    end
  end

endmodule

// File: src/alpha_box_blur_region.sv
// ----------------------------------------------------------------------------
// alpha_box_blur_region
// region alpha box blur over a raster argb stream, with apb register port
// ----------------------------------------------------------------------------
// Pixels enter in raster order and leave in the same order with their column
// and row; inside the region the alpha becomes the truncated mean of the
// window around it. The front end takes one request per cycle while its
// two-entry job queue has room. The back end owns the single-port line store
// and handles one job at a time: it takes the job in the idle state, writes
// the pixel in the write state when the job carries one, then makes one store
// read per window tap ((2R+1)^2 taps inside the region, one tap outside), and
// passes through states for the last read, the reciprocal multiply and the
// result register, then holds the result in the output state until it is
// taken. The line store needs no clearing pass after reset. Writes to the
// seven registers restart the stream.
// ----------------------------------------------------------------------------
`include "alpha_box_blur_region_assert.svh"

module alpha_box_blur_region import abb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_out_o,
  output logic [9:0]  out_col_o,
  output logic [9:0]  out_row_o,
  output logic        frame_end_o
);

  logic [10:0] fw_q, fh_q, rw_q, rh_q;
  logic [9:0]  rl_q, rt_q;
  logic [1:0]  rad_q;
  logic [2:0]  idx;
  logic        wr_en, restart;
  cfg_t        cfg;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_out;

  assign pready  = 1'b1;
  assign idx     = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign restart = wr_en && ({29'd0, idx} < 32'(NumRegs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 11'd1024;
      fh_q  <= 11'd1024;
      rl_q  <= '0;
      rt_q  <= '0;
      rw_q  <= '0;
      rh_q  <= '0;
      rad_q <= 2'd3;
    end else if (wr_en) begin
      case (idx)
        RegFrameWidth:  fw_q  <= pwdata[10:0];
        RegFrameHeight: fh_q  <= pwdata[10:0];
        RegRegionLeft:  rl_q  <= pwdata[9:0];
        RegRegionTop:   rt_q  <= pwdata[9:0];
        RegRegionW:     rw_q  <= pwdata[10:0];
        RegRegionH:     rh_q  <= pwdata[10:0];
        RegBlurRadius:  rad_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegFrameWidth:  prdata = {21'd0, fw_q};
      RegFrameHeight: prdata = {21'd0, fh_q};
      RegRegionLeft:  prdata = {22'd0, rl_q};
      RegRegionTop:   prdata = {22'd0, rt_q};
      RegRegionW:     prdata = {21'd0, rw_q};
      RegRegionH:     prdata = {21'd0, rh_q};
      RegBlurRadius:  prdata = {30'd0, rad_q};
      default:        prdata = '0;
    endcase
  end

  // clamp sizes to what the line store holds
  always_comb begin
    cfg.width  = (fw_q == 11'd0) ? 11'd1 :
                 (fw_q > 11'(MaxWidth)) ? 11'(MaxWidth) : fw_q;
    cfg.height = (fh_q == 11'd0) ? 11'd1 :
                 (fh_q > 11'd1024) ? 11'd1024 : fh_q;
    cfg.left   = rl_q;
    cfg.top    = rt_q;
    cfg.reg_w  = rw_q;
    cfg.reg_h  = rh_q;
    cfg.radius = (rad_q > 2'(MaxRadius)) ? 2'(MaxRadius) : rad_q;
  end

  abb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .pixel_in_i (pixel_in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_in)
  );

  abb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (restart),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (q_out)
  );

  abb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flush_i     (restart),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_job_i     (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .frame_end_o (frame_end_o)
  );

  `ABB_ASSERT_NEVER(a_no_push_full, q_push && q_full, "job pushed into full queue")
  `ABB_ASSERT(a_pop_nonempty, q_pop |-> !q_empty, "job popped from empty queue")
  `ABB_ASSERT(a_end_last_col, (out_valid_o && frame_end_o) |-> ({1'b0, out_col_o} == cfg.width - 11'd1), "frame end off last column")

endmodule
